@@ sv/i2csb_pkg.sv @@
// i2csb_pkg: shared types and constants of the single-byte I2C master.
// No dependencies; compiled first.
`default_nettype none

package i2csb_pkg;

    // Default build values
    localparam int BUS_FREE_TRIES_DEF   = 100;
    localparam int MAJORITY_SAMPLES_DEF = 5;

    // Field widths
    localparam int ADDR_W = 7;
    localparam int HALF_W = 10;
    localparam int CFG_W  = 10;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 4;

    // Register reset values and the delay counter limit
    localparam logic [ADDR_W-1:0] ADDR_RST = 7'd47;
    localparam logic [HALF_W-1:0] HALF_RST = 10'd30;
    localparam logic [HALF_W-1:0] DELAY_MAX = 10'd1023;

    // Configuration register indexes
    typedef enum logic {
        CFG_SLAVE_ADDR  = 1'b0,
        CFG_HALF_PERIOD = 1'b1
    } t_cfg_idx;

    // Command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
    localparam logic [1:0] ST_ADDR_NACK = 2'd2;
    localparam logic [1:0] ST_DATA_NACK = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST_SDA_HI  = 5'd1,
        PH_ST_SCL_HI  = 5'd2,
        PH_ST_CHECK   = 5'd3,
        PH_ST_SDA_LO  = 5'd4,
        PH_ST_SCL_LO  = 5'd5,
        PH_ST_GAP     = 5'd6,
        PH_TX_SCL_LO  = 5'd7,
        PH_TX_SDA     = 5'd8,
        PH_TX_SCL_HI  = 5'd9,
        PH_ACK_SCL_LO = 5'd10,
        PH_ACK_SDA_HI = 5'd11,
        PH_ACK_SCL_HI = 5'd12,
        PH_ACK_END    = 5'd13,
        PH_RX_SCL_LO  = 5'd14,
        PH_RX_SCL_HI  = 5'd15,
        PH_RX_SAMPLE  = 5'd16,
        PH_NK_SCL_LO  = 5'd17,
        PH_NK_SDA_HI  = 5'd18,
        PH_NK_SCL_HI  = 5'd19,
        PH_NK_END     = 5'd20,
        PH_SP_SDA_LO  = 5'd21,
        PH_SP_SCL_LO  = 5'd22,
        PH_SP_SCL_HI  = 5'd23,
        PH_SP_SDA_HI  = 5'd24
    } t_phase;

endpackage

`default_nettype wire

@@ sv/i2csb_in_if.sv @@
// i2csb_in_if: tick channel into the I2C master (command, data byte, SDA sample).
// Valid/ready handshake; no dependencies.
`default_nettype none

interface i2csb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output opcode, output write_data, output sda_in,
                    input ready);
    modport sink   (input valid, input opcode, input write_data, input sda_in,
                    output ready);
endinterface

`default_nettype wire

@@ sv/i2csb_out_if.sv @@
// i2csb_out_if: per-tick result channel of the I2C master (pin drives, status).
// Valid/ready handshake; no dependencies.
`default_nettype none

interface i2csb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output status, output read_data, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input status, input read_data, output ready);
endinterface

`default_nettype wire

@@ sv/i2c_single_byte_master.sv @@
// Single-byte I2C master. Each transfer on i_in is one bus tick: it carries the
// sampled SDA level and, while idle, an optional write or read command. Every
// tick yields one result transfer on o_out with the SCL/SDA drives, busy, a
// one-tick done pulse, the last status and the last byte read. One tick is
// taken per clock cycle; the sequencer state is updated in the same cycle the
// tick is accepted and the result sits in a single output register, so a new
// tick is accepted whenever that register is empty or being drained. Timing on
// the bus is counted in ticks (half_period_ticks per phase), not clock cycles.
// Depends on i2csb_pkg, i2csb_in_if and i2csb_out_if.
`default_nettype none

module i2c_single_byte_master #(
    parameter int BUS_FREE_TRIES   = i2csb_pkg::BUS_FREE_TRIES_DEF,
    parameter int MAJORITY_SAMPLES = i2csb_pkg::MAJORITY_SAMPLES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire [i2csb_pkg::CFG_W-1:0] i_cfg_data,
    i2csb_in_if.sink                  i_in,
    i2csb_out_if.source               o_out
);
    import i2csb_pkg::*;

    localparam int FT_W = (BUS_FREE_TRIES > 2) ? $clog2(BUS_FREE_TRIES) : 1;
    localparam int HS_W = $clog2(MAJORITY_SAMPLES + 1);
    localparam logic [FT_W-1:0]   FT_LIMIT = FT_W'(BUS_FREE_TRIES - 1);
    localparam logic [HS_W-1:0]   HS_HALF  = HS_W'(MAJORITY_SAMPLES / 2);
    localparam logic [HALF_W-1:0] MAJ_CNT  = HALF_W'(MAJORITY_SAMPLES);

    // Configuration
    logic [ADDR_W-1:0] r_slave_address;
    logic [HALF_W-1:0] r_half_period;

    // Sequencer state
    t_phase            r_phase, n_phase;
    logic [HALF_W-1:0] r_delay, n_delay;
    logic [BIT_W-1:0]  r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [HS_W-1:0]   r_high_cnt, n_high_cnt;
    logic [FT_W-1:0]   r_free_tries, n_free_tries;
    logic              r_is_read, n_is_read;
    logic [1:0]        r_status, n_status;
    logic [BYTE_W-1:0] r_rx_byte, n_rx_byte;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic [BYTE_W-1:0] r_data_hold, n_data_hold;
    logic              r_second, n_second;
    logic [1:0]        r_pend, n_pend;
    logic              n_done;

    // Output register
    logic              r_out_valid;
    logic              r_out_scl;
    logic              r_out_sda;
    logic              r_out_busy;
    logic              r_out_done;
    logic [1:0]        r_out_status;
    logic [BYTE_W-1:0] r_out_rx;

    logic              in_ready;
    logic              in_xfer;
    logic [HALF_W-1:0] half_eff;
    logic [HALF_W-1:0] delay_inc;
    logic              delay_done;
    logic              go;
    t_phase            go_phase;
    logic [FT_W-1:0]   tries_inc;
    logic [HS_W-1:0]   high_inc;
    logic [BIT_W-1:0]  bit_inc;

    // no transfer is taken while reset is held
    assign in_ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign in_xfer  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign half_eff   = (r_half_period == '0) ? HALF_W'(1) : r_half_period;
    assign delay_inc  = (r_delay < DELAY_MAX) ? r_delay + HALF_W'(1) : r_delay;
    assign delay_done = delay_inc >= half_eff;
    assign tries_inc  = r_free_tries + FT_W'(1);
    assign high_inc   = r_high_cnt + HS_W'(i_in.sda_in);
    assign bit_inc    = r_bit_idx + BIT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_delay      = r_delay;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_high_cnt   = r_high_cnt;
        n_free_tries = r_free_tries;
        n_is_read    = r_is_read;
        n_status     = r_status;
        n_rx_byte    = r_rx_byte;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_data_hold  = r_data_hold;
        n_second     = r_second;
        n_pend       = r_pend;
        n_done       = 1'b0;
        go           = 1'b0;
        go_phase     = PH_IDLE;

        case (r_phase)
            PH_IDLE: begin
                if (i_in.opcode == OP_WRITE || i_in.opcode == OP_READ) begin
                    n_is_read   = (i_in.opcode == OP_READ);
                    n_data_hold = i_in.write_data;
                    n_second    = 1'b0;
                    n_pend      = ST_OK;
                    n_bit_idx   = '0;
                    n_shift     = {r_slave_address, i_in.opcode == OP_READ};
                    go          = 1'b1;
                    go_phase    = PH_ST_SDA_HI;
                end
            end
            PH_ST_CHECK: begin
                if (i_in.sda_in) begin
                    go       = 1'b1;
                    go_phase = PH_ST_SDA_LO;
                end else begin
                    n_free_tries = tries_inc;
                    if (tries_inc >= FT_LIMIT) begin
                        n_phase  = PH_IDLE;
                        n_delay  = '0;
                        n_done   = 1'b1;
                        n_status = ST_BUS_BUSY;
                    end
                end
            end
            PH_RX_SAMPLE: begin
                n_high_cnt = high_inc;
                n_delay    = r_delay + HALF_W'(1);
                if (n_delay >= MAJ_CNT) begin
                    n_shift   = {r_shift[BYTE_W-2:0], high_inc > HS_HALF};
                    n_bit_idx = bit_inc;
                    go        = 1'b1;
                    go_phase  = (bit_inc < BIT_W'(BYTE_W)) ? PH_RX_SCL_LO : PH_NK_SCL_LO;
                end
            end
            PH_ST_SDA_HI, PH_ST_SCL_HI, PH_ST_SDA_LO, PH_ST_SCL_LO, PH_ST_GAP,
            PH_TX_SCL_LO, PH_TX_SDA, PH_TX_SCL_HI, PH_ACK_SCL_LO, PH_ACK_SDA_HI,
            PH_ACK_SCL_HI, PH_ACK_END, PH_RX_SCL_LO, PH_RX_SCL_HI, PH_NK_SCL_LO,
            PH_NK_SDA_HI, PH_NK_SCL_HI, PH_NK_END, PH_SP_SDA_LO, PH_SP_SCL_LO,
            PH_SP_SCL_HI, PH_SP_SDA_HI: begin
                n_delay = delay_inc;
                if (delay_done) begin
                    go = 1'b1;
                    case (r_phase)
                        PH_ST_SDA_HI:  go_phase = PH_ST_SCL_HI;
                        PH_ST_SCL_HI:  go_phase = PH_ST_CHECK;
                        PH_ST_SDA_LO:  go_phase = PH_ST_SCL_LO;
                        PH_ST_SCL_LO:  go_phase = PH_ST_GAP;
                        PH_ST_GAP: begin
                            n_bit_idx = '0;
                            go_phase  = PH_TX_SCL_LO;
                        end
                        PH_TX_SCL_LO:  go_phase = PH_TX_SDA;
                        PH_TX_SDA:     go_phase = PH_TX_SCL_HI;
                        PH_TX_SCL_HI: begin
                            n_bit_idx = bit_inc;
                            go_phase  = (bit_inc < BIT_W'(BYTE_W)) ? PH_TX_SCL_LO
                                                                   : PH_ACK_SCL_LO;
                        end
                        PH_ACK_SCL_LO: go_phase = PH_ACK_SDA_HI;
                        PH_ACK_SDA_HI: go_phase = PH_ACK_SCL_HI;
                        PH_ACK_SCL_HI: begin
                            // ACK sampled on the last tick of SCL high
                            n_pend   = !i_in.sda_in ? ST_OK
                                     : (r_second ? ST_DATA_NACK : ST_ADDR_NACK);
                            go_phase = PH_ACK_END;
                        end
                        PH_ACK_END: begin
                            if (r_pend != ST_OK || r_second) begin
                                go_phase = PH_SP_SDA_LO;
                            end else if (r_is_read) begin
                                n_bit_idx = '0;
                                n_shift   = '0;
                                go_phase  = PH_RX_SCL_LO;
                            end else begin
                                n_second  = 1'b1;
                                n_bit_idx = '0;
                                n_shift   = r_data_hold;
                                go_phase  = PH_TX_SCL_LO;
                            end
                        end
                        PH_RX_SCL_LO:  go_phase = PH_RX_SCL_HI;
                        PH_RX_SCL_HI:  go_phase = PH_RX_SAMPLE;
                        PH_NK_SCL_LO:  go_phase = PH_NK_SDA_HI;
                        PH_NK_SDA_HI:  go_phase = PH_NK_SCL_HI;
                        PH_NK_SCL_HI:  go_phase = PH_NK_END;
                        PH_NK_END: begin
                            n_pend   = ST_OK;
                            go_phase = PH_SP_SDA_LO;
                        end
                        PH_SP_SDA_LO:  go_phase = PH_SP_SCL_LO;
                        PH_SP_SCL_LO:  go_phase = PH_SP_SCL_HI;
                        PH_SP_SCL_HI:  go_phase = PH_SP_SDA_HI;
                        PH_SP_SDA_HI: begin
                            go       = 1'b0;
                            n_phase  = PH_IDLE;
                            n_delay  = '0;
                            n_done   = 1'b1;
                            n_status = r_pend;
                            if (r_pend == ST_OK && r_is_read) begin
                                n_rx_byte = r_shift;
                            end
                        end
                        default: go = 1'b0;
                    endcase
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        // Entering a phase: restart the delay and apply the phase's pin drive, counter clear or shift
        if (go) begin
            n_phase = go_phase;
            n_delay = '0;
            case (go_phase)
                PH_ST_SDA_HI:  n_sda = 1'b1;
                PH_ST_SCL_HI:  n_scl = 1'b1;
                PH_ST_CHECK:   n_free_tries = '0;
                PH_ST_SDA_LO:  n_sda = 1'b0;
                PH_ST_SCL_LO:  n_scl = 1'b0;
                PH_TX_SCL_LO:  n_scl = 1'b0;
                PH_TX_SDA: begin
                    n_sda   = n_shift[BYTE_W-1];
                    n_shift = {n_shift[BYTE_W-2:0], 1'b0};
                end
                PH_TX_SCL_HI:  n_scl = 1'b1;
                PH_ACK_SCL_LO: n_scl = 1'b0;
                PH_ACK_SDA_HI: n_sda = 1'b1;
                PH_ACK_SCL_HI: n_scl = 1'b1;
                PH_ACK_END:    n_scl = 1'b0;
                PH_RX_SCL_LO: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_RX_SCL_HI: begin
                    n_scl      = 1'b1;
                    n_high_cnt = '0;
                end
                PH_NK_SCL_LO:  n_scl = 1'b0;
                PH_NK_SDA_HI:  n_sda = 1'b1;
                PH_NK_SCL_HI:  n_scl = 1'b1;
                PH_NK_END:     n_scl = 1'b0;
                PH_SP_SDA_LO:  n_sda = 1'b0;
                PH_SP_SCL_LO:  n_scl = 1'b0;
                PH_SP_SCL_HI:  n_scl = 1'b1;
                PH_SP_SDA_HI:  n_sda = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= ADDR_RST;
            r_half_period   <= HALF_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SLAVE_ADDR:  r_slave_address <= i_cfg_data[ADDR_W-1:0];
                CFG_HALF_PERIOD: r_half_period   <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_delay      <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_high_cnt   <= '0;
            r_free_tries <= '0;
            r_is_read    <= 1'b0;
            r_status     <= ST_OK;
            r_rx_byte    <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_data_hold  <= '0;
            r_second     <= 1'b0;
            r_pend       <= ST_OK;
        end else if (in_xfer) begin
            r_phase      <= n_phase;
            r_delay      <= n_delay;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_high_cnt   <= n_high_cnt;
            r_free_tries <= n_free_tries;
            r_is_read    <= n_is_read;
            r_status     <= n_status;
            r_rx_byte    <= n_rx_byte;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_data_hold  <= n_data_hold;
            r_second     <= n_second;
            r_pend       <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_busy   <= (n_phase != PH_IDLE);
            r_out_done   <= n_done;
            r_out_status <= n_status;
            r_out_rx     <= n_rx_byte;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_out_scl;
    assign o_out.sda_out   = r_out_sda;
    assign o_out.busy_res  = r_out_busy;
    assign o_out.done_res  = r_out_done;
    assign o_out.status    = r_out_status;
    assign o_out.read_data = r_out_rx;

endmodule

`default_nettype wire

@@ sv/i2csb_checker.sv @@
// i2csb_checker: port-level assertions for i2c_single_byte_master, bound to
// the top level below. Depends on i2csb_pkg and the top level.
`default_nettype none

module i2csb_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_out_busy,
    input wire       i_out_done,
    input wire [1:0] i_out_status
);
    import i2csb_pkg::*;

    // A finishing tick never reports the bus as still busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> !i_out_busy)
        else $error("done pulse with busy set");

    // An empty result slot always leaves room for the next tick
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // Nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // A held result keeps its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("stalled result changed");

    // No accepted tick is lost: a transfer in is always followed by a valid result
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted tick without result");

endmodule

bind i2c_single_byte_master i2csb_checker u_i2csb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_busy   (o_out.busy_res),
    .i_out_done   (o_out.done_res),
    .i_out_status (o_out.status)
);

`default_nettype wire

@@ tb/i2c_single_byte_master_tb.sv @@
// Testbench for the single-byte I2C master: random and directed bus ticks are checked
// against a tick-by-tick predictor of the sequencer. It depends on i2csb_pkg,
// i2csb_in_if, i2csb_out_if and i2c_single_byte_master.
module i2c_single_byte_master_tb;
    import i2csb_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_AT     = 1500;
    localparam int         HOLD_CYCLES = 200;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         TICK_BUDGET = 1950;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] wdata;
        logic       sda;
    } t_tick_item;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [1:0] status;
        logic [7:0] rdata;
    } t_pin_result;

    typedef struct packed {
        t_phase     phase;
        logic [9:0] delay;
        logic [3:0] bit_idx;
        logic [7:0] shreg;
        logic [2:0] highs;
        logic [6:0] tries;
        logic       is_read;
        logic [1:0] status;
        logic [7:0] rx_byte;
        logic       scl;
        logic       sda;
        logic [7:0] data_byte;
        logic       on_data;
        logic [1:0] pend_status;
        logic       done;
        logic [6:0] slave_addr;
        logic [9:0] half_ticks;
    } t_master_model;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_SLAVE_ADDR;
    logic [9:0]  cfg_data = '0;
    logic        tick_valid = 1'b0;
    t_tick_item  tick_cur = '0;
    logic        pin_ready = 1'b0;

    t_tick_item    ticks_to_send[$];
    t_pin_result   pins_due[$];
    t_master_model plan_model;
    t_master_model live_model;

    int tick_wait = 0;
    int tick_run = 0;
    int pin_hold = 0;
    int pin_run = 0;
    int ticks_planned = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int done_by_status[4] = '{default: 0};

    i2csb_in_if  tick_if ();
    i2csb_out_if pin_if ();

    assign tick_if.valid      = tick_valid;
    assign tick_if.opcode     = tick_cur.op;
    assign tick_if.write_data = tick_cur.wdata;
    assign tick_if.sda_in     = tick_cur.sda;
    assign pin_if.ready       = pin_ready;

    i2c_single_byte_master i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_if),
        .o_out      (pin_if)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic t_master_model master_at_reset();
        t_master_model m;
        m = '0;
        m.phase      = PH_IDLE;
        m.scl        = 1'b1;
        m.sda        = 1'b1;
        m.slave_addr = ADDR_RST;
        m.half_ticks = HALF_RST;
        return m;
    endfunction

    function automatic void apply_reg(inout t_master_model m, input t_cfg_idx idx,
                                      input logic [9:0] value);
        if (idx == CFG_SLAVE_ADDR)
            m.slave_addr = value[6:0];
        else
            m.half_ticks = value;
    endfunction

    function automatic void enter_phase(inout t_master_model m, input t_phase p);
        m.phase = p;
        m.delay = '0;
        case (p)
            PH_ST_SDA_HI, PH_ACK_SDA_HI, PH_NK_SDA_HI, PH_SP_SDA_HI: m.sda = 1'b1;
            PH_ST_SCL_HI, PH_TX_SCL_HI, PH_ACK_SCL_HI, PH_NK_SCL_HI,
            PH_SP_SCL_HI: m.scl = 1'b1;
            PH_ST_CHECK: m.tries = '0;
            PH_ST_SDA_LO, PH_SP_SDA_LO: m.sda = 1'b0;
            PH_ST_SCL_LO, PH_TX_SCL_LO, PH_ACK_SCL_LO, PH_ACK_END, PH_NK_SCL_LO,
            PH_NK_END, PH_SP_SCL_LO: m.scl = 1'b0;
            PH_TX_SDA: begin
                m.sda   = m.shreg[7];
                m.shreg = {m.shreg[6:0], 1'b0};
            end
            PH_RX_SCL_LO: begin
                m.scl = 1'b0;
                m.sda = 1'b1;
            end
            PH_RX_SCL_HI: begin
                m.scl   = 1'b1;
                m.highs = '0;
            end
            default: ;
        endcase
    endfunction

    // counts one tick of the current phase; a zero half period behaves as one
    function automatic logic half_elapsed(inout t_master_model m);
        logic [9:0] lim;
        lim = (m.half_ticks == '0) ? 10'd1 : m.half_ticks;
        if (m.delay < DELAY_MAX)
            m.delay = m.delay + 10'd1;
        return m.delay >= lim;
    endfunction

    function automatic void close_transaction(inout t_master_model m, input logic [1:0] st);
        m.phase  = PH_IDLE;
        m.delay  = '0;
        m.done   = 1'b1;
        m.status = st;
        if (st == ST_OK && m.is_read)
            m.rx_byte = m.shreg;
    endfunction

    function automatic void begin_stop(inout t_master_model m, input logic [1:0] st);
        m.pend_status = st;
        enter_phase(m, PH_SP_SDA_LO);
    endfunction

    function automatic t_pin_result predict_tick(inout t_master_model m, input t_tick_item t);
        t_pin_result r;
        logic        bit_val;
        m.done = 1'b0;
        if (m.phase == PH_IDLE) begin
            if (t.op == OP_WRITE || t.op == OP_READ) begin
                m.is_read     = (t.op == OP_READ);
                m.data_byte   = t.wdata;
                m.on_data     = 1'b0;
                m.pend_status = ST_OK;
                m.bit_idx     = '0;
                m.shreg       = {m.slave_addr, m.is_read};
                enter_phase(m, PH_ST_SDA_HI);
            end
        end else begin
            case (m.phase)
                PH_ST_SDA_HI: if (half_elapsed(m)) enter_phase(m, PH_ST_SCL_HI);
                PH_ST_SCL_HI: if (half_elapsed(m)) enter_phase(m, PH_ST_CHECK);
                PH_ST_CHECK: begin
                    if (t.sda) begin
                        enter_phase(m, PH_ST_SDA_LO);
                    end else begin
                        m.tries = m.tries + 7'd1;
                        if (m.tries >= 7'(BUS_FREE_TRIES_DEF - 1))
                            close_transaction(m, ST_BUS_BUSY);
                    end
                end
                PH_ST_SDA_LO: if (half_elapsed(m)) enter_phase(m, PH_ST_SCL_LO);
                PH_ST_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_ST_GAP);
                PH_ST_GAP: if (half_elapsed(m)) begin
                    m.bit_idx = '0;
                    enter_phase(m, PH_TX_SCL_LO);
                end
                PH_TX_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_TX_SDA);
                PH_TX_SDA: if (half_elapsed(m)) enter_phase(m, PH_TX_SCL_HI);
                PH_TX_SCL_HI: if (half_elapsed(m)) begin
                    m.bit_idx = m.bit_idx + 4'd1;
                    enter_phase(m, (m.bit_idx < 4'd8) ? PH_TX_SCL_LO : PH_ACK_SCL_LO);
                end
                PH_ACK_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_ACK_SDA_HI);
                PH_ACK_SDA_HI: if (half_elapsed(m)) enter_phase(m, PH_ACK_SCL_HI);
                PH_ACK_SCL_HI: if (half_elapsed(m)) begin
                    // ack is taken on the last tick of SCL high only
                    if (t.sda)
                        m.pend_status = m.on_data ? ST_DATA_NACK : ST_ADDR_NACK;
                    else
                        m.pend_status = ST_OK;
                    enter_phase(m, PH_ACK_END);
                end
                PH_ACK_END: if (half_elapsed(m)) begin
                    if (m.pend_status != ST_OK) begin
                        begin_stop(m, m.pend_status);
                    end else if (m.on_data) begin
                        begin_stop(m, ST_OK);
                    end else if (m.is_read) begin
                        m.bit_idx = '0;
                        m.shreg   = '0;
                        enter_phase(m, PH_RX_SCL_LO);
                    end else begin
                        m.on_data = 1'b1;
                        m.bit_idx = '0;
                        m.shreg   = m.data_byte;
                        enter_phase(m, PH_TX_SCL_LO);
                    end
                end
                PH_RX_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_RX_SCL_HI);
                PH_RX_SCL_HI: if (half_elapsed(m)) enter_phase(m, PH_RX_SAMPLE);
                PH_RX_SAMPLE: begin
                    if (t.sda && m.highs < 3'd7)
                        m.highs = m.highs + 3'd1;
                    m.delay = m.delay + 10'd1;
                    if (m.delay >= 10'(MAJORITY_SAMPLES_DEF)) begin
                        bit_val   = (m.highs > 3'(MAJORITY_SAMPLES_DEF / 2));
                        m.shreg   = {m.shreg[6:0], bit_val};
                        m.bit_idx = m.bit_idx + 4'd1;
                        if (m.bit_idx < 4'd8) begin
                            enter_phase(m, PH_RX_SCL_LO);
                        end else begin
                            m.scl = 1'b0;
                            enter_phase(m, PH_NK_SCL_LO);
                        end
                    end
                end
                PH_NK_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_NK_SDA_HI);
                PH_NK_SDA_HI: if (half_elapsed(m)) enter_phase(m, PH_NK_SCL_HI);
                PH_NK_SCL_HI: if (half_elapsed(m)) enter_phase(m, PH_NK_END);
                PH_NK_END: if (half_elapsed(m)) begin_stop(m, ST_OK);
                PH_SP_SDA_LO: if (half_elapsed(m)) enter_phase(m, PH_SP_SCL_LO);
                PH_SP_SCL_LO: if (half_elapsed(m)) enter_phase(m, PH_SP_SCL_HI);
                PH_SP_SCL_HI: if (half_elapsed(m)) enter_phase(m, PH_SP_SDA_HI);
                PH_SP_SDA_HI: if (half_elapsed(m)) close_transaction(m, m.pend_status);
                default: m.phase = PH_IDLE;
            endcase
        end
        r.scl    = m.scl;
        r.sda    = m.sda;
        r.busy   = (m.phase != PH_IDLE);
        r.done   = m.done;
        r.status = m.status;
        r.rdata  = m.rx_byte;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus planning

    // SDA as a slave would answer, given where the master stands before this tick
    function automatic logic bus_answer(input t_master_model m, input logic addr_nack,
                                        input logic data_nack, input int free_lows,
                                        input logic [7:0] rx_byte, input int noise_pct);
        logic [9:0] lim;
        logic [9:0] nxt;
        lim = (m.half_ticks == '0) ? 10'd1 : m.half_ticks;
        nxt = (m.delay < DELAY_MAX) ? m.delay + 10'd1 : m.delay;
        case (m.phase)
            PH_ST_CHECK: return (int'(m.tries) >= free_lows);
            PH_ACK_SCL_HI: if (nxt >= lim) return m.on_data ? data_nack : addr_nack;
            PH_RX_SAMPLE: return rx_byte[3'd7 - m.bit_idx[2:0]] ^
                                 ($urandom_range(0, 99) < noise_pct);
            default: ;
        endcase
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_tick(input t_tick_item t);
        void'(predict_tick(plan_model, t));
        ticks_to_send.push_back(t);
        ticks_planned++;
    endtask

    task automatic plan_idle(input int n);
        t_tick_item t;
        repeat (n) begin
            t.op    = $urandom_range(0, 1) ? OP_UNUSED : OP_TICK;
            t.wdata = 8'($urandom);
            t.sda   = 1'($urandom_range(0, 1));
            push_tick(t);
        end
    endtask

    // one whole transaction; stray_pct sets how often a command is offered while busy
    task automatic plan_transaction(input logic [1:0] op, input logic [7:0] wdata,
                                    input logic addr_nack, input logic data_nack,
                                    input int free_lows, input logic [7:0] rx_byte,
                                    input int noise_pct, input int stray_pct);
        t_tick_item t;
        t.op    = op;
        t.wdata = wdata;
        t.sda   = 1'($urandom_range(0, 1));
        push_tick(t);
        while (plan_model.phase != PH_IDLE) begin
            t.op    = ($urandom_range(0, 99) < stray_pct) ? 2'($urandom_range(1, 3)) : OP_TICK;
            t.wdata = 8'($urandom);
            t.sda   = bus_answer(plan_model, addr_nack, data_nack, free_lows, rx_byte,
                                 noise_pct);
            push_tick(t);
        end
    endtask

    task automatic drain();
        while (ticks_to_send.size() != 0 || tick_valid || pins_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [9:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        apply_reg(plan_model, idx, value);
        apply_reg(live_model, idx, value);
    endtask

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            run_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin : drive_ticks
        logic       offer;
        t_tick_item nxt;
        if (!i_rst_n) begin
            tick_valid <= 1'b0;
            tick_wait = 0;
        end else begin
            if (tick_valid && tick_if.ready)
                pins_due.push_back(predict_tick(live_model, tick_cur));
            if (!tick_valid || tick_if.ready) begin
                offer = 1'b0;
                if (tick_wait > 0) begin
                    tick_wait--;
                end else if (ticks_to_send.size() > 0) begin
                    nxt       = ticks_to_send.pop_front();
                    tick_cur <= nxt;
                    offer     = 1'b1;
                    tick_wait = draw_gap(tick_run);
                end
                tick_valid <= offer;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : watch_pins
        t_pin_result want;
        if (!i_rst_n) begin
            pin_ready <= 1'b0;
            pin_hold = 0;
        end else begin
            if (pin_ready && pin_if.valid) begin
                results_seen++;
                if (pin_if.done_res)
                    done_by_status[pin_if.status]++;
                if (pins_due.size() == 0) begin
                    $error("result transfer with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = pins_due.pop_front();
                    check_field("scl_out", want.scl, pin_if.scl_out);
                    check_field("sda_out", want.sda, pin_if.sda_out);
                    check_field("busy_res", want.busy, pin_if.busy_res);
                    check_field("done_res", want.done, pin_if.done_res);
                    check_field("status", want.status, pin_if.status);
                    check_field("read_data", want.rdata, pin_if.read_data);
                end
                // one long hold-off so the output register fills and input stalls
                pin_hold = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(pin_run);
            end
            if (pin_hold > 0) begin
                pin_hold--;
                pin_ready <= 1'b0;
            end else begin
                pin_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_valid && tick_if.ready) || (pin_ready && pin_if.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $error("no transfer on either channel for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : stimulus
        int         phase_end;
        int         lows;
        logic [9:0] half;
        logic [9:0] addr;
        t_tick_item first;
        plan_model = master_at_reset();
        live_model = master_at_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain ticks only, then the reset address with a short half period
        plan_idle(4);
        drain();
        write_reg(CFG_HALF_PERIOD, 10'd1);
        settings_used++;
        plan_transaction(OP_WRITE, 8'hA5, 1'b0, 1'b0, 0, 8'h00, 0, 0);
        drain();
        write_reg(CFG_SLAVE_ADDR, 10'd0);
        settings_used++;
        plan_transaction(OP_WRITE, 8'h00, 1'b0, 1'b0, 0, 8'h00, 0, 0);
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 0, 8'h00, 0, 0);
        drain();
        write_reg(CFG_SLAVE_ADDR, 10'd127);
        settings_used++;
        plan_transaction(OP_WRITE, 8'hFF, 1'b0, 1'b0, 0, 8'h00, 0, 0);
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 0, 8'hFF, 0, 0);
        // noisy samples exercise the majority vote
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 0, 8'h5A, 35, 0);
        plan_transaction(OP_WRITE, 8'h3C, 1'b1, 1'b0, 0, 8'h00, 0, 0);
        plan_transaction(OP_WRITE, 8'hC3, 1'b0, 1'b1, 0, 8'h00, 0, 0);
        plan_transaction(OP_READ, 8'h00, 1'b1, 1'b0, 0, 8'h00, 0, 0);
        // bus held low for a while, then never released
        plan_transaction(OP_WRITE, 8'h81, 1'b0, 1'b0, 7, 8'h00, 0, 0);
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 99, 8'h00, 0, 0);
        // commands offered while busy must be ignored
        plan_transaction(OP_WRITE, 8'h66, 1'b0, 1'b0, 0, 8'h00, 0, 30);
        plan_idle(3);
        drain();
        write_reg(CFG_HALF_PERIOD, 10'd0);
        settings_used++;
        plan_transaction(OP_WRITE, 8'($urandom), 1'b0, 1'b0, 0, 8'h00, 0, 0);
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 0, 8'($urandom), 0, 0);
        drain();
        write_reg(CFG_HALF_PERIOD, 10'd1023);
        write_reg(CFG_SLAVE_ADDR, 10'($urandom_range(0, 127)));
        settings_used++;
        // longest half period for the first phase, shortened part way through it
        first.op    = OP_WRITE;
        first.wdata = 8'($urandom);
        first.sda   = 1'b1;
        push_tick(first);
        plan_idle(40);
        drain();
        write_reg(CFG_HALF_PERIOD, 10'd1);
        settings_used++;
        // the read command lands mid-transaction and is dropped; the bus never frees
        plan_transaction(OP_READ, 8'h00, 1'b0, 1'b0, 120, 8'h00, 0, 5);
        plan_idle(2);

        // random part: mostly well-formed transactions on short half periods
        while (ticks_planned < TICK_BUDGET) begin
            drain();
            case ($urandom_range(0, 3))
                0: half = 10'd1;
                1: half = 10'd2;
                2: half = 10'($urandom_range(3, 5));
                default: half = 10'($urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 3))
                0: addr = 10'd0;
                1: addr = 10'd127;
                default: addr = 10'($urandom_range(0, 127));
            endcase
            write_reg(CFG_HALF_PERIOD, half);
            write_reg(CFG_SLAVE_ADDR, addr);
            settings_used++;
            phase_end = ticks_planned + 400;
            while (ticks_planned < phase_end) begin
                case ($urandom_range(0, 19))
                    19: lows = $urandom_range(99, 110);
                    15, 16, 17, 18: lows = $urandom_range(1, 30);
                    default: lows = 0;
                endcase
                plan_transaction($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom),
                                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                                 lows, 8'($urandom),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0, 4);
                plan_idle($urandom_range(0, 4));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("%0d ticks checked over %0d register settings, half period 0 to 1023",
                 results_seen, settings_used);
        $display("transactions ended: %0d ok, %0d bus not free, %0d address nack, %0d data nack",
                 done_by_status[ST_OK], done_by_status[ST_BUS_BUSY],
                 done_by_status[ST_ADDR_NACK], done_by_status[ST_DATA_NACK]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ i2c_single_byte_master.f @@
sv/i2csb_pkg.sv
sv/i2csb_in_if.sv
sv/i2csb_out_if.sv
sv/i2c_single_byte_master.sv
sv/i2csb_checker.sv
tb/i2c_single_byte_master_tb.sv
